// ===== design/flbm_pkg.sv =====
// Shared types and constants for the four-layer background mixer.
// Used by every module of the block; depends on nothing.
package flbm_pkg;

  typedef enum logic [1:0] {
    CmdLoadGfx   = 2'd0,
    CmdLoadMix   = 2'd1,
    CmdBeginLine = 2'd2,
    CmdPixel     = 2'd3
  } cmd_e;

  // configuration register indexes
  localparam logic [2:0] CfgScrollX      = 3'd0;
  localparam logic [2:0] CfgRowSelect    = 3'd1;
  localparam logic [2:0] CfgWindowCounts = 3'd2;
  localparam logic [2:0] CfgMixSelect    = 3'd3;
  localparam logic [2:0] CfgFlip         = 3'd4;

  localparam int unsigned Layers    = 4;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoCntW  = 3;

  // pen = 0x200 | bank << 4 | layer << 2 | pixel
  localparam logic [1:0] PenTop = 2'b10;

  // control that travels with a pixel tick down the pipeline
  typedef struct packed {
    logic       valid;
    logic       emit;
    logic [3:0] mix_bank;
    logic [3:0] pen_bank;
  } tick_t;

  typedef logic [Layers-1:0][1:0] pix_t;

endpackage

// ===== design/flbm_layer_fetch.sv =====
// Per-layer scroll and window counters plus one graphics memory per layer.
// Produces the four layer pixels, registered, in the cycle after a pixel tick; uses flbm_pkg.
module flbm_layer_fetch #(
  parameter int unsigned ROWS_PER_LAYER = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  flbm_pkg::cmd_e        cmd_i,
  input  logic [14:0]           load_address_i,
  input  logic [7:0]            load_data_i,
  input  logic                  emit_i,
  input  logic [31:0]           scroll_x_i,
  input  logic [31:0]           row_select_i,
  input  logic [31:0]           window_counts_i,
  input  logic [7:0]            mix_select_i,
  input  logic                  flip_i,
  output flbm_pkg::tick_t       tick_o,
  output flbm_pkg::pix_t        pix_o
);

  localparam int unsigned GfxDepth = ROWS_PER_LAYER * 32;
  localparam int unsigned GfxAw    = $clog2(GfxDepth);
  localparam logic [8:0]  RowLimit = 9'(ROWS_PER_LAYER);

  logic tick_acc, gfx_load;
  logic [7:0] wr_row;
  logic [12:0] wr_full;
  logic wr_row_ok;
  flbm_pkg::tick_t tick_q;

  assign tick_acc  = accept_i && (cmd_i == flbm_pkg::CmdPixel);
  assign gfx_load  = accept_i && (cmd_i == flbm_pkg::CmdLoadGfx);
  assign wr_row    = load_address_i[12:5];
  assign wr_full   = load_address_i[12:0];
  assign wr_row_ok = {1'b0, wr_row} < RowLimit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
    end else begin
      tick_q.valid    <= tick_acc;
      tick_q.emit     <= emit_i;
      tick_q.mix_bank <= mix_select_i[3:0];
      tick_q.pen_bank <= mix_select_i[7:4];
    end
  end

  assign tick_o = tick_q;

  for (genvar gi = 0; gi < flbm_pkg::Layers; gi++) begin : g_lane
    logic [7:0] mem [GfxDepth];
    logic [7:0] x_q, x_d;
    logic [4:0] start_q, start_d, stop_q, stop_d;
    logic [7:0] row, wbyte;
    logic [12:0] rd_full;
    logic row_ok, wclk;
    logic [7:0] gfx_q;
    logic [1:0] p_q;
    logic vis_q;

    assign row     = row_select_i[8*gi +: 8];
    assign wbyte   = window_counts_i[8*gi +: 8];
    assign row_ok  = {1'b0, row} < RowLimit;
    assign rd_full = {row, x_q[6:2]};

    always_comb begin
      x_d     = x_q;
      start_d = start_q;
      stop_d  = stop_q;
      wclk    = 1'b0;
      if (accept_i && cmd_i == flbm_pkg::CmdBeginLine) begin
        x_d     = scroll_x_i[8*gi +: 8];
        start_d = {1'b0, wbyte[3:0]};
        stop_d  = {1'b0, wbyte[7:4]};
      end else if (tick_acc) begin
        if (!flip_i) begin
          x_d  = x_q + 8'd1;
          wclk = (x_d[4:0] == 5'd0);
        end else begin
          x_d  = x_q - 8'd1;
          wclk = (x_q[4:0] == 5'd0);
        end
        if (wclk) begin
          start_d = start_q + 5'd1;
          stop_d  = stop_q + 5'd1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        x_q     <= '0;
        start_q <= '0;
        stop_q  <= '0;
      end else begin
        x_q     <= x_d;
        start_q <= start_d;
        stop_q  <= stop_d;
      end
    end

    // read-before-write: a load issued after a tick does not reach that tick
    always_ff @(posedge clk_i) begin
      if (gfx_load && wr_row_ok && load_address_i[14:13] == 2'(gi)) begin
        mem[wr_full[GfxAw-1:0]] <= load_data_i;
      end
      gfx_q <= mem[rd_full[GfxAw-1:0]];
      p_q   <= x_q[1:0];
      vis_q <= (start_q[4] ^ stop_q[4]) && !x_q[7] && row_ok;
    end

    assign pix_o[gi] = vis_q ? {gfx_q[4 + p_q], gfx_q[p_q]} : 2'b00;
  end

endmodule

// ===== design/flbm_mixer.sv =====
// Mixer PROM memory and pen composition for the four layer pixels.
// Takes the fetch stage's pixels and tick control; uses flbm_pkg.
module flbm_mixer #(
  parameter int unsigned MIXER_ENTRIES = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  logic [14:0]     wr_addr_i,
  input  logic [1:0]      wr_data_i,
  input  flbm_pkg::tick_t tick_i,
  input  flbm_pkg::pix_t  pix_i,
  output logic            push_o,
  output logic [9:0]      pen_o
);

  localparam int unsigned MixAw    = $clog2(MIXER_ENTRIES);
  localparam logic [14:0] MixLimit = 15'(MIXER_ENTRIES);

  logic [1:0] mem [MIXER_ENTRIES];
  logic [7:0] midx;
  logic [3:0] flags;
  logic [1:0] mix_q, chosen;
  logic in_range_q;
  flbm_pkg::pix_t pix_q;
  flbm_pkg::tick_t tick_q;

  for (genvar gi = 0; gi < flbm_pkg::Layers; gi++) begin : g_flag
    assign flags[gi] = (pix_i[gi] != 2'b00);
  end

  assign midx = {tick_i.mix_bank, flags};

  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_addr_i < MixLimit) begin
      mem[wr_addr_i[MixAw-1:0]] <= wr_data_i;
    end
    mix_q      <= mem[midx[MixAw-1:0]];
    in_range_q <= {7'd0, midx} < MixLimit;
    pix_q      <= pix_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
    end else begin
      tick_q <= tick_i;
    end
  end

  // out-of-range PROM index selects layer 0
  assign chosen = in_range_q ? mix_q : 2'd0;
  assign pen_o  = {flbm_pkg::PenTop, tick_q.pen_bank, chosen, pix_q[chosen]};
  assign push_o = tick_q.valid && tick_q.emit;

endmodule

// ===== design/flbm_out_fifo.sv =====
// Small output queue that decouples the pen pipeline from the receiver.
// Never overflows: the top level reserves a slot per emitting tick; uses flbm_pkg.
module flbm_out_fifo (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [9:0] data_i,
  output logic       valid_o,
  input  logic       ready_i,
  output logic [9:0] data_o
);

  localparam int unsigned PtrW = $clog2(flbm_pkg::FifoDepth);

  logic [9:0] mem [flbm_pkg::FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [flbm_pkg::FifoCntW-1:0] cnt_q;
  logic pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign data_o  = mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_q + flbm_pkg::FifoCntW'(push_i) - flbm_pkg::FifoCntW'(pop);
    end
  end

endmodule

// ===== design/four_layer_background_mixer.sv =====
// Four-layer background mixer: top level with configuration registers.
// Instantiates flbm_layer_fetch, flbm_mixer and flbm_out_fifo; uses flbm_pkg.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one command per transfer:
//   load graphics byte, load mixer entry, begin line, or pixel tick.
//   A pixel tick with emit_i set yields one pen on the output channel
//   (out_valid_o/out_ready_i); all other commands yield nothing.
//   Configuration writes use cfg_valid_i/cfg_ready_o; cfg_ready_o is always
//   high. Write them only while the block is idle.
//   A pen is registered in the fetch stage, the mixer stage and the output
//   queue before it is presented on the output channel.
//   Throughput: one command per cycle while in_ready_o is high; the graphics memories (one per layer)
//   and the mixer PROM each take one read per cycle in their own stage.
//   The output queue holds four pens; in_ready_o drops once four pens are
//   queued or in flight, so a stalled receiver stalls the input after at
//   most four emitting ticks, and nothing is lost.
//   Reset clears counters, configuration and tick registers and the queue; the graphics and mixer
//   memories keep no reset value and must be loaded before they are read.
module four_layer_background_mixer #(
  parameter int unsigned ROWS_PER_LAYER = 256,
  parameter int unsigned MIXER_ENTRIES  = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [14:0] load_address_i,
  input  logic [7:0]  load_data_i,
  input  logic        emit_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [9:0]  pen_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] scroll_x_q, row_select_q, window_counts_q;
  logic [7:0]  mix_select_q;
  logic        flip_q;
  logic        accept, cfg_we, push, pop, reserve;
  logic [flbm_pkg::FifoCntW-1:0] reserved_q;
  logic [9:0]  pen_new;
  flbm_pkg::cmd_e  cmd;
  flbm_pkg::tick_t tick;
  flbm_pkg::pix_t  pix;

  assign cmd         = flbm_pkg::cmd_e'(cmd_i);
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;
  assign in_ready_o  = reserved_q < flbm_pkg::FifoCntW'(flbm_pkg::FifoDepth);
  assign accept      = in_valid_i && in_ready_o;
  assign reserve     = accept && (cmd == flbm_pkg::CmdPixel) && emit_i;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scroll_x_q      <= '0;
      row_select_q    <= '0;
      window_counts_q <= '0;
      mix_select_q    <= '0;
      flip_q          <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        flbm_pkg::CfgScrollX:      scroll_x_q      <= cfg_data_i;
        flbm_pkg::CfgRowSelect:    row_select_q    <= cfg_data_i;
        flbm_pkg::CfgWindowCounts: window_counts_q <= cfg_data_i;
        flbm_pkg::CfgMixSelect:    mix_select_q    <= cfg_data_i[7:0];
        flbm_pkg::CfgFlip:         flip_q          <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // slots held by pens queued or still in the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reserved_q <= '0;
    end else begin
      reserved_q <= reserved_q + flbm_pkg::FifoCntW'(reserve)
                    - flbm_pkg::FifoCntW'(pop);
    end
  end

  flbm_layer_fetch #(
    .ROWS_PER_LAYER(ROWS_PER_LAYER)
  ) u_fetch (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .cmd_i          (cmd),
    .load_address_i (load_address_i),
    .load_data_i    (load_data_i),
    .emit_i         (emit_i),
    .scroll_x_i     (scroll_x_q),
    .row_select_i   (row_select_q),
    .window_counts_i(window_counts_q),
    .mix_select_i   (mix_select_q),
    .flip_i         (flip_q),
    .tick_o         (tick),
    .pix_o          (pix)
  );

  flbm_mixer #(
    .MIXER_ENTRIES(MIXER_ENTRIES)
  ) u_mixer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (accept && cmd == flbm_pkg::CmdLoadMix),
    .wr_addr_i(load_address_i),
    .wr_data_i(load_data_i[1:0]),
    .tick_i   (tick),
    .pix_i    (pix),
    .push_o   (push),
    .pen_o    (pen_new)
  );

  flbm_out_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (pen_new),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .data_o (pen_o)
  );

endmodule
